// File: hdl/indexed_list_engine_defines.svh
// Assertion macros used by the checker of the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ILE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ile_pkg.sv
// Types and constants shared by the indexed list engine modules.
`timescale 1ns / 1ps

package ile_pkg;

  // Field widths of the request and result items.
  localparam int MODE_W    = 3;
  localparam int POS_W     = 7;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  // Read value reported for an invalid index.
  localparam logic [VALUE_W-1:0] READ_INVALID = '1;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_END  = 3'd1,
    MODE_INS_AT   = 3'd2,
    MODE_READ     = 3'd3,
    MODE_DEL_HEAD = 3'd4,
    MODE_DEL_TAIL = 3'd5,
    MODE_DEL_AT   = 3'd6
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [VALUE_W-1:0]   value;
  } cell_cmd_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

// File: hdl/indexed_list_engine.sv
// Insert, delete and rejected requests put their result in the output register in the
// cycle after acceptance; a valid read at position p puts its result there once the read
// chain has moved the element from cell p toward cell 0, one cell per cycle.
// Throughput: one request at a time, a new one is taken as soon as the result is taken.
// Reset (rst, synchronous, active high) empties the list and clears the output; the
// element cells are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module indexed_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata fields from bit 0: mode[2:0], position[9:3], value[41:10], zero fill
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,
  // m_tdata fields from bit 0: status[1:0], read_value[33:2], element_count[40:34],
  // zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ile_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Request fields.
  logic [ile_pkg::MODE_W-1:0]  in_mode;
  logic [ile_pkg::POS_W-1:0]   in_position;
  logic [ile_pkg::VALUE_W-1:0] in_value;

  assign in_mode     = s_tdata[2:0];
  assign in_position = s_tdata[9:3];
  assign in_value    = s_tdata[41:10];

  // Control state.
  ile_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_wait;
  logic             out_valid;

  // Payload registers.
  logic [CNT_W-1:0]                rd_pos;
  ile_pkg::status_t                out_status;
  logic signed [ile_pkg::VALUE_W-1:0] out_read_value;
  logic [ile_pkg::COUNT_W-1:0]     out_count;

  // Decoded request.
  ile_pkg::status_t            dec_status;
  logic [ile_pkg::VALUE_W-1:0] dec_rd;
  ile_pkg::cell_op_t           dec_op;
  logic [CNT_W-1:0]            dec_at;
  logic [CNT_W-1:0]            dec_count;
  logic                        dec_read;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CNT_W-1:0] pos_at;
  logic             full;
  logic             empty;

  // Handshake and chain control.
  logic               accept;
  logic               rd_done;
  ile_pkg::cell_cmd_t cmd;

  // Chain wiring.
  logic [ile_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic [ile_pkg::VALUE_W-1:0] cell_rd   [CAPACITY];

  assign pos_x  = CMP_W'(in_position);
  assign cnt_x  = CMP_W'(count);
  assign pos_at = CNT_W'(pos_x);
  assign full   = (count == CNT_FULL);
  assign empty  = (count == '0);

  // Request decode: status, read value, shift command and new count.
  always_comb begin
    dec_status = ile_pkg::ST_OK;
    dec_rd     = '0;
    dec_op     = ile_pkg::CELL_HOLD;
    dec_at     = '0;
    dec_count  = count;
    dec_read   = 1'b0;
    case (ile_pkg::mode_t'(in_mode))
      ile_pkg::MODE_INS_HEAD: begin
        if (full) begin
          dec_status = ile_pkg::ST_FULL;
        end else begin
          dec_op    = ile_pkg::CELL_INSERT;
          dec_count = count + CNT_ONE;
        end
      end
      ile_pkg::MODE_INS_END: begin
        if (full) begin
          dec_status = ile_pkg::ST_FULL;
        end else begin
          dec_op    = ile_pkg::CELL_INSERT;
          dec_at    = count;
          dec_count = count + CNT_ONE;
        end
      end
      ile_pkg::MODE_INS_AT: begin
        if (pos_x > cnt_x) begin
          dec_status = ile_pkg::ST_BAD_INDEX;
          dec_rd     = ile_pkg::READ_INVALID;
        end else if (full) begin
          dec_status = ile_pkg::ST_FULL;
        end else begin
          dec_op    = ile_pkg::CELL_INSERT;
          dec_at    = pos_at;
          dec_count = count + CNT_ONE;
        end
      end
      ile_pkg::MODE_READ: begin
        if (pos_x >= cnt_x) begin
          dec_status = ile_pkg::ST_BAD_INDEX;
          dec_rd     = ile_pkg::READ_INVALID;
        end else begin
          dec_read = 1'b1;
        end
      end
      ile_pkg::MODE_DEL_HEAD: begin
        if (empty) begin
          dec_status = ile_pkg::ST_EMPTY;
        end else begin
          dec_op    = ile_pkg::CELL_DELETE;
          dec_count = count - CNT_ONE;
        end
      end
      ile_pkg::MODE_DEL_TAIL: begin
        // The tail only drops out of the count; no element moves.
        if (empty) begin
          dec_status = ile_pkg::ST_EMPTY;
        end else begin
          dec_count = count - CNT_ONE;
        end
      end
      ile_pkg::MODE_DEL_AT: begin
        if (empty) begin
          dec_status = ile_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = ile_pkg::ST_BAD_INDEX;
          dec_rd     = ile_pkg::READ_INVALID;
        end else begin
          dec_op    = ile_pkg::CELL_DELETE;
          dec_at    = pos_at;
          dec_count = count - CNT_ONE;
        end
      end
      default: begin
        dec_status = ile_pkg::ST_BAD_INDEX;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ile_pkg::S_IDLE: begin
        if (accept && dec_read) begin
          state_next = ile_pkg::S_READ;
        end
      end
      ile_pkg::S_READ: begin
        if (rd_wait == '0) begin
          state_next = ile_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ile_pkg::S_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    s_tready  = 1'b0;
    rd_done   = 1'b0;
    cmd.op    = ile_pkg::CELL_HOLD;
    cmd.value = in_value;
    case (state)
      ile_pkg::S_IDLE: begin
        s_tready = !out_valid || m_tready;
        if (s_tvalid && s_tready) begin
          cmd.op = dec_op;
        end
      end
      ile_pkg::S_READ: begin
        rd_done = (rd_wait == '0);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ile_pkg::S_IDLE;
      count     <= '0;
      rd_wait   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count     <= dec_count;
        rd_wait   <= pos_at + CNT_ONE;
        out_valid <= !dec_read;
      end else if (rd_done) begin
        out_valid <= 1'b1;
      end else if (state == ile_pkg::S_READ) begin
        rd_wait <= rd_wait - CNT_ONE;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result and read position registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= dec_status;
      out_count  <= ile_pkg::COUNT_W'(dec_count);
      rd_pos     <= pos_at;
      if (!dec_read) begin
        out_read_value <= dec_rd;
      end
    end else if (rd_done) begin
      out_read_value <= cell_rd[0];
    end
  end

  // Chain of element cells; cell 0 is the head of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ile_pkg::VALUE_W-1:0] left_d;
    logic [ile_pkg::VALUE_W-1:0] right_d;
    logic [ile_pkg::VALUE_W-1:0] rd_in_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
      assign rd_in_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_data[i+1];
      assign rd_in_d = cell_rd[i+1];
    end

    ile_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .at         (dec_at),
      .rd_pos     (rd_pos),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_in      (rd_in_d),
      .data       (cell_data[i]),
      .rd_q       (cell_rd[i])
    );
  end

  // Result channel.
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_count, out_read_value, out_status};

endmodule

// File: hdl/ile_cell.sv
// One storage cell of the element chain: holds one element and one read-chain stage.
`timescale 1ns / 1ps

module ile_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                          clk,
  input  ile_pkg::cell_cmd_t            cmd,
  input  logic [CNT_W-1:0]              at,
  input  logic [CNT_W-1:0]              rd_pos,
  input  logic [ile_pkg::VALUE_W-1:0]   left_data,
  input  logic [ile_pkg::VALUE_W-1:0]   right_data,
  input  logic [ile_pkg::VALUE_W-1:0]   rd_in,
  output logic [ile_pkg::VALUE_W-1:0]   data,
  output logic [ile_pkg::VALUE_W-1:0]   rd_q
);

  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

  // Element register: shifts toward the tail on insert, toward the head on delete.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ile_pkg::CELL_INSERT: begin
        if (MY_INDEX == at) begin
          data <= cmd.value;
        end else if (MY_INDEX > at) begin
          data <= left_data;
        end
      end
      ile_pkg::CELL_DELETE: begin
        if (MY_INDEX >= at) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

  // Read chain stage: the selected cell injects its element, the others pass it headward.
  always_ff @(posedge clk) begin
    rd_q <= (MY_INDEX == rd_pos) ? data : rd_in;
  end

endmodule

// File: hdl/ile_checker.sv
// Port-level checker of the indexed list engine and its bind statement.
`timescale 1ns / 1ps
`include "indexed_list_engine_defines.svh"

module ile_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ile_pkg::M_TDATA_W-1:0]  m_tdata
);

  logic [ile_pkg::STATUS_W-1:0] r_status;
  logic [ile_pkg::VALUE_W-1:0]  r_value;
  logic [ile_pkg::COUNT_W-1:0]  r_count;

  assign r_status = m_tdata[1:0];
  assign r_value  = m_tdata[33:2];
  assign r_count  = m_tdata[40:34];

  // A stalled result keeps its contents.
  `ILE_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // A rejected insert into a full list reports no read value.
  `ILE_ASSERT_SAME(a_full_no_value, m_tvalid && (r_status == ile_pkg::ST_FULL), r_value == '0, "full result carries a read value")

  // An empty-list result means the list stays empty and no value is read.
  `ILE_ASSERT_SAME(a_empty_count, m_tvalid && (r_status == ile_pkg::ST_EMPTY), (r_count == '0) && (r_value == '0), "empty result with nonzero count or value")

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
